[rtl/ppc_pkg.sv]
package ppc_pkg;

  localparam int unsigned CoordW = 32;
  localparam int unsigned CountW = 7;
  localparam int unsigned ValW   = 64;
  localparam int unsigned QW     = 31;
  localparam int unsigned FracT  = 30;
  localparam int unsigned BufN   = 4;

  typedef enum logic [3:0] {
    OP_NOP       = 4'd0,
    OP_LOAD      = 4'd1,
    OP_START     = 4'd2,
    OP_EDGE_SEL  = 4'd3,
    OP_MUL       = 4'd4,
    OP_ACC       = 4'd5,
    OP_DIV_INIT  = 4'd6,
    OP_DIV_STEP  = 4'd7,
    OP_LERP_MUL  = 4'd8,
    OP_LERP_ACC  = 4'd9,
    OP_PUSH_INT  = 4'd10,
    OP_PUSH_END  = 4'd11,
    OP_PUSH_NONE = 4'd12,
    OP_FINISH    = 4'd13,
    OP_EMIT      = 4'd14
  } op_e;

  typedef struct packed {
    op_e        op;
    logic [2:0] sel;
  } cmd_t;

  typedef struct packed {
    logic       have_first;
    logic       last;
    logic       in1;
    logic       in2;
    logic       den_zero;
    logic [2:0] nbuf;
    logic       out_free;
  } status_t;

  typedef struct packed {
    logic [CoordW-1:0] x;
    logic [CoordW-1:0] y;
    logic [CoordW-1:0] z;
    logic              valid;
    logic [CountW-1:0] count;
  } result_t;

  typedef enum logic [1:0] {
    REG_A = 2'd0,
    REG_B = 2'd1,
    REG_C = 2'd2,
    REG_D = 2'd3
  } reg_e;

endpackage

[rtl/ppc_regs.sv]
module ppc_regs (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [3:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready,
  output logic [31:0] plane_a_o,
  output logic [31:0] plane_b_o,
  output logic [31:0] plane_c_o,
  output logic [31:0] plane_d_o
);

  logic [31:0] a_q, b_q, c_q, d_q;
  logic        we;
  ppc_pkg::reg_e idx;

  assign pready = 1'b1;
  assign we     = psel && penable && pwrite;
  assign idx    = ppc_pkg::reg_e'(paddr[3:2]);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      a_q <= 32'h0000_0000;
      b_q <= 32'h0000_0000;
      c_q <= 32'hFFFF_0000;
      d_q <= 32'h0001_0000;
    end else if (we) begin
      unique case (idx)
        ppc_pkg::REG_A: a_q <= pwdata;
        ppc_pkg::REG_B: b_q <= pwdata;
        ppc_pkg::REG_C: c_q <= pwdata;
        ppc_pkg::REG_D: d_q <= pwdata;
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (idx)
      ppc_pkg::REG_A: prdata = a_q;
      ppc_pkg::REG_B: prdata = b_q;
      ppc_pkg::REG_C: prdata = c_q;
      ppc_pkg::REG_D: prdata = d_q;
      default:        prdata = a_q;
    endcase
  end

  assign plane_a_o = a_q;
  assign plane_b_o = b_q;
  assign plane_c_o = c_q;
  assign plane_d_o = d_q;

endmodule

[rtl/ppc_ctrl.sv]
module ppc_ctrl (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_stall_o,
  input  ppc_pkg::status_t  status_i,
  output ppc_pkg::cmd_t     cmd_o
);

  typedef enum logic [14:0] {
    S_IDLE  = 15'b000000000000001,
    S_START = 15'b000000000000010,
    S_EDGE  = 15'b000000000000100,
    S_MUL   = 15'b000000000001000,
    S_ACC   = 15'b000000000010000,
    S_CLASS = 15'b000000000100000,
    S_DIVI  = 15'b000000001000000,
    S_DIVS  = 15'b000000010000000,
    S_LMUL  = 15'b000000100000000,
    S_LACC  = 15'b000001000000000,
    S_PINT  = 15'b000010000000000,
    S_PEND  = 15'b000100000000000,
    S_NEXT  = 15'b001000000000000,
    S_FIN   = 15'b010000000000000,
    S_EMIT  = 15'b100000000000000
  } state_e;

  state_e     state_q, state_d;
  logic [2:0] k_q, k_d;
  logic [4:0] cnt_q, cnt_d;
  logic       edge_q, edge_d;
  logic       none_q, none_d;

  assign in_stall_o = (state_q != S_IDLE);

  always_comb begin
    state_d = state_q;
    k_d     = k_q;
    cnt_d   = cnt_q;
    edge_d  = edge_q;
    none_d  = none_q;
    cmd_o.op  = ppc_pkg::OP_NOP;
    cmd_o.sel = k_q;
    unique case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          cmd_o.op = ppc_pkg::OP_LOAD;
          state_d  = S_START;
        end
      end
      S_START: begin
        cmd_o.op = ppc_pkg::OP_START;
        none_d   = 1'b0;
        if (status_i.have_first) begin
          edge_d  = 1'b0;
          state_d = S_EDGE;
        end else if (status_i.last) begin
          edge_d  = 1'b1;
          state_d = S_EDGE;
        end else begin
          state_d = S_FIN;
        end
      end
      S_EDGE: begin
        cmd_o.op  = ppc_pkg::OP_EDGE_SEL;
        cmd_o.sel = {2'b00, edge_q};
        k_d       = 3'd0;
        state_d   = S_MUL;
      end
      S_MUL: begin
        cmd_o.op = ppc_pkg::OP_MUL;
        state_d  = S_ACC;
      end
      S_ACC: begin
        cmd_o.op = ppc_pkg::OP_ACC;
        if (k_q == 3'd5) begin
          state_d = S_CLASS;
        end else begin
          k_d     = k_q + 3'd1;
          state_d = S_MUL;
        end
      end
      S_CLASS: begin
        if (!status_i.in1 && !status_i.in2) begin
          state_d = S_NEXT;
        end else if (status_i.in1 && status_i.in2) begin
          state_d = S_PEND;
        end else if (status_i.den_zero) begin
          state_d = S_NEXT;
        end else begin
          state_d = S_DIVI;
        end
      end
      S_DIVI: begin
        cmd_o.op = ppc_pkg::OP_DIV_INIT;
        cnt_d    = 5'd0;
        state_d  = S_DIVS;
      end
      S_DIVS: begin
        cmd_o.op = ppc_pkg::OP_DIV_STEP;
        if (cnt_q == 5'(ppc_pkg::FracT - 1)) begin
          k_d     = 3'd0;
          state_d = S_LMUL;
        end else begin
          cnt_d = cnt_q + 5'd1;
        end
      end
      S_LMUL: begin
        cmd_o.op = ppc_pkg::OP_LERP_MUL;
        state_d  = S_LACC;
      end
      S_LACC: begin
        cmd_o.op = ppc_pkg::OP_LERP_ACC;
        if (k_q == 3'd2) begin
          state_d = S_PINT;
        end else begin
          k_d     = k_q + 3'd1;
          state_d = S_LMUL;
        end
      end
      S_PINT: begin
        cmd_o.op = ppc_pkg::OP_PUSH_INT;
        state_d  = status_i.in2 ? S_PEND : S_NEXT;
      end
      S_PEND: begin
        cmd_o.op = ppc_pkg::OP_PUSH_END;
        state_d  = S_NEXT;
      end
      S_NEXT: begin
        if (!edge_q && status_i.last) begin
          edge_d  = 1'b1;
          state_d = S_EDGE;
        end else if (status_i.last && (status_i.nbuf == 3'd0) && !none_q) begin
          cmd_o.op = ppc_pkg::OP_PUSH_NONE;
          none_d   = 1'b1;
          state_d  = S_FIN;
        end else begin
          state_d = S_FIN;
        end
      end
      S_FIN: begin
        cmd_o.op = ppc_pkg::OP_FINISH;
        k_d      = 3'd0;
        state_d  = (status_i.nbuf == 3'd0) ? S_IDLE : S_EMIT;
      end
      S_EMIT: begin
        if (status_i.out_free) begin
          cmd_o.op = ppc_pkg::OP_EMIT;
          if (k_q == status_i.nbuf - 3'd1) begin
            state_d = S_IDLE;
          end else begin
            k_d = k_q + 3'd1;
          end
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      k_q     <= 3'd0;
      cnt_q   <= 5'd0;
      edge_q  <= 1'b0;
      none_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      k_q     <= k_d;
      cnt_q   <= cnt_d;
      edge_q  <= edge_d;
      none_q  <= none_d;
    end
  end

endmodule

[rtl/ppc_datapath.sv]
module ppc_datapath #(
  parameter int unsigned MAX_VERTICES = 64
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  ppc_pkg::cmd_t     cmd_i,
  output ppc_pkg::status_t  status_o,
  input  logic [31:0]       plane_a_i,
  input  logic [31:0]       plane_b_i,
  input  logic [31:0]       plane_c_i,
  input  logic [31:0]       plane_d_i,
  input  logic [31:0]       in_x_i,
  input  logic [31:0]       in_y_i,
  input  logic [31:0]       in_z_i,
  input  logic              last_vertex_i,
  input  logic              out_stall_i,
  output logic              out_valid_o,
  output logic [31:0]       out_x_o,
  output logic [31:0]       out_y_o,
  output logic [31:0]       out_z_o,
  output logic              vertex_valid_o,
  output logic              run_last_o,
  output logic              polygon_done_o,
  output logic [6:0]        out_count_o
);

  localparam int unsigned CapInt = ((MAX_VERTICES + 1) < 127) ? (MAX_VERTICES + 1) : 127;
  localparam logic [ppc_pkg::CountW-1:0] OutCap = ppc_pkg::CountW'(CapInt);

  logic [31:0] cur_q [3];
  logic [31:0] prev_q [3];
  logic [31:0] first_q [3];
  logic [31:0] p1_q [3];
  logic [31:0] p2_q [3];
  logic [31:0] ip_q [3];
  logic        last_q, have_first_q;
  logic [ppc_pkg::CountW-1:0] cnt_q;
  ppc_pkg::result_t buf_q [ppc_pkg::BufN];
  logic [2:0]  nbuf_q;

  logic signed [63:0] prod_q, acc_q, v1_q, v2_q;
  logic [63:0] rem_q, ud_q, lprod_q;
  logic [ppc_pkg::QW-1:0] q_q;
  logic        dneg_q;

  logic        ovalid_q;
  ppc_pkg::result_t ores_q;
  logic        orl_q, opd_q;

  logic [1:0]  j;
  logic [31:0] coord;
  logic signed [63:0] nacc, den, un, udn;
  logic [63:0] r2;
  logic signed [32:0] dif;
  logic [32:0] mag;
  logic [33:0] off, p1x, resw;
  logic [63:0] lround;
  logic        push, push_valid;
  logic [31:0] px, py, pz;
  logic [ppc_pkg::CountW-1:0] cnt_new;

  assign j = cmd_i.sel[1:0];

  // step codes 0..2 walk the start point, 3..5 the end point
  always_comb begin
    unique case (cmd_i.sel)
      3'd0: begin coord = p1_q[0]; end
      3'd1: begin coord = p1_q[1]; end
      3'd2: begin coord = p1_q[2]; end
      3'd3: begin coord = p2_q[0]; end
      3'd4: begin coord = p2_q[1]; end
      default: begin coord = p2_q[2]; end
    endcase
  end

  logic [31:0] mcoef;
  always_comb begin
    unique case (cmd_i.sel)
      3'd0, 3'd3: mcoef = plane_a_i;
      3'd1, 3'd4: mcoef = plane_b_i;
      default:    mcoef = plane_c_i;
    endcase
  end

  assign nacc = acc_q + (prod_q >>> 16);
  assign den  = v2_q - v1_q;
  assign un   = v1_q[63] ? -v1_q : v1_q;
  assign udn  = den[63] ? -den : den;
  assign r2   = {rem_q[62:0], 1'b0};

  assign dif    = {p2_q[j][31], p2_q[j]} - {p1_q[j][31], p1_q[j]};
  assign mag    = dif[32] ? 33'(-dif) : 33'(dif);
  assign lround = lprod_q + (64'd1 << (ppc_pkg::FracT - 1));
  assign off    = lround[ppc_pkg::FracT +: 34];
  assign p1x    = {{2{p1_q[j][31]}}, p1_q[j]};
  assign resw   = dneg_q ? (p1x - off) : (p1x + off);

  always_comb begin
    push       = 1'b0;
    push_valid = 1'b1;
    px = ip_q[0];
    py = ip_q[1];
    pz = ip_q[2];
    unique case (cmd_i.op)
      ppc_pkg::OP_PUSH_INT: push = 1'b1;
      ppc_pkg::OP_PUSH_END: begin
        push = 1'b1;
        px = p2_q[0];
        py = p2_q[1];
        pz = p2_q[2];
      end
      ppc_pkg::OP_PUSH_NONE: begin
        push       = 1'b1;
        push_valid = 1'b0;
        px = 32'd0;
        py = 32'd0;
        pz = 32'd0;
      end
      default: ;
    endcase
    cnt_new = (push_valid && (cnt_q < OutCap)) ? cnt_q + 1'b1 : cnt_q;
  end

  always_ff @(posedge clk_i) begin
    unique case (cmd_i.op)
      ppc_pkg::OP_LOAD: begin
        cur_q[0] <= in_x_i;
        cur_q[1] <= in_y_i;
        cur_q[2] <= in_z_i;
        last_q   <= last_vertex_i;
      end
      ppc_pkg::OP_START: begin
        if (!have_first_q) begin
          first_q <= cur_q;
        end
      end
      ppc_pkg::OP_EDGE_SEL: begin
        if (cmd_i.sel[0]) begin
          p1_q <= cur_q;
          p2_q <= first_q;
        end else begin
          p1_q <= prev_q;
          p2_q <= cur_q;
        end
        acc_q <= 64'(signed'(plane_d_i));
      end
      ppc_pkg::OP_MUL: begin
        prod_q <= 64'(signed'(mcoef)) * 64'(signed'(coord));
      end
      ppc_pkg::OP_ACC: begin
        if (cmd_i.sel == 3'd2) begin
          v1_q  <= nacc;
          acc_q <= 64'(signed'(plane_d_i));
        end else if (cmd_i.sel == 3'd5) begin
          v2_q <= nacc;
        end else begin
          acc_q <= nacc;
        end
      end
      ppc_pkg::OP_DIV_INIT: begin
        ud_q <= udn;
        if (un >= udn) begin
          rem_q <= un - udn;
          q_q   <= ppc_pkg::QW'(1);
        end else begin
          rem_q <= un;
          q_q   <= '0;
        end
      end
      ppc_pkg::OP_DIV_STEP: begin
        if (r2 >= ud_q) begin
          rem_q <= r2 - ud_q;
          q_q   <= {q_q[ppc_pkg::QW-2:0], 1'b1};
        end else begin
          rem_q <= r2;
          q_q   <= {q_q[ppc_pkg::QW-2:0], 1'b0};
        end
      end
      ppc_pkg::OP_LERP_MUL: begin
        lprod_q <= 64'(mag) * 64'(q_q);
        dneg_q  <= dif[32];
      end
      ppc_pkg::OP_LERP_ACC: begin
        ip_q[j] <= resw[31:0];
      end
      ppc_pkg::OP_FINISH: begin
        prev_q <= cur_q;
      end
      default: ;
    endcase
    if (push && (nbuf_q < 3'(ppc_pkg::BufN))) begin
      buf_q[nbuf_q[1:0]] <= '{x: px, y: py, z: pz, valid: push_valid, count: cnt_new};
    end
    if (cmd_i.op == ppc_pkg::OP_EMIT) begin
      ores_q <= buf_q[cmd_i.sel[1:0]];
      orl_q  <= (cmd_i.sel == nbuf_q - 3'd1);
      opd_q  <= last_q;
    end
  end

  // control state: first-vertex flag, count, fill level, output valid
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      have_first_q <= 1'b0;
      cnt_q        <= '0;
      nbuf_q       <= 3'd0;
      ovalid_q     <= 1'b0;
    end else begin
      if (cmd_i.op == ppc_pkg::OP_START) begin
        have_first_q <= 1'b1;
        nbuf_q       <= 3'd0;
      end
      if (push && (nbuf_q < 3'(ppc_pkg::BufN))) begin
        nbuf_q <= nbuf_q + 3'd1;
        cnt_q  <= cnt_new;
      end
      if ((cmd_i.op == ppc_pkg::OP_FINISH) && last_q) begin
        have_first_q <= 1'b0;
        cnt_q        <= '0;
      end
      if (cmd_i.op == ppc_pkg::OP_EMIT) begin
        ovalid_q <= 1'b1;
      end else if (!out_stall_i) begin
        ovalid_q <= 1'b0;
      end
    end
  end

  assign status_o.have_first = have_first_q;
  assign status_o.last       = last_q;
  assign status_o.in1        = v1_q[63];
  assign status_o.in2        = v2_q[63];
  assign status_o.den_zero   = (den == 64'sd0);
  assign status_o.nbuf       = nbuf_q;
  assign status_o.out_free   = !ovalid_q || !out_stall_i;

  assign out_valid_o    = ovalid_q;
  assign out_x_o        = ores_q.x;
  assign out_y_o        = ores_q.y;
  assign out_z_o        = ores_q.z;
  assign vertex_valid_o = ores_q.valid;
  assign run_last_o     = orl_q;
  assign polygon_done_o = opd_q;
  assign out_count_o    = ores_q.count;

endmodule

[rtl/polygon_plane_clipper_unit.sv]
// Polygon plane clipper: a Sutherland-Hodgman clip stage in 3D, Q16.16.
// Input channel: one vertex per transfer (in_x/y/z, last_vertex flags the
// final vertex). Output channel: clipped vertices with vertex_valid,
// run_last (last result of that input), polygon_done and out_count.
// Plane coefficients a, b, c, d are written over the APB port at byte
// addresses 0, 4, 8, 12; write them only while the block is idle.
// Each input goes through accept, start and finish, plus each edge it
// closes: the two plane values, then, for a crossing, the restoring
// divider and the interpolation, then the pushes. A last vertex also runs
// the closing edge. Results leave at one per cycle while the output does
// not stall. The block takes one item at a time; the shared multiplier and
// the serial divider set its pace, and output stalls add to it.
// Reset: plane = -z + 1 (a=0, b=0, c=-1.0, d=+1.0), no first vertex held,
// count cleared. A stall on the output holds the result register; the block
// holds its remaining results and stalls the input until all are taken.
module polygon_plane_clipper_unit #(
  parameter int unsigned MAX_VERTICES = 64
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [3:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic [31:0] in_x_i,
  input  logic [31:0] in_y_i,
  input  logic [31:0] in_z_i,
  input  logic        last_vertex_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic [31:0] out_x_o,
  output logic [31:0] out_y_o,
  output logic [31:0] out_z_o,
  output logic        vertex_valid_o,
  output logic        run_last_o,
  output logic        polygon_done_o,
  output logic [6:0]  out_count_o
);

  localparam int unsigned CapInt = ((MAX_VERTICES + 1) < 127) ? (MAX_VERTICES + 1) : 127;

  logic [31:0] plane_a, plane_b, plane_c, plane_d;
  ppc_pkg::cmd_t    cmd;
  ppc_pkg::status_t status;

  // plane coefficient registers
  ppc_regs u_regs (
    .clk_i, .rst_ni, .psel, .penable, .pwrite, .paddr, .pwdata, .prdata, .pready,
    .plane_a_o(plane_a), .plane_b_o(plane_b), .plane_c_o(plane_c), .plane_d_o(plane_d)
  );

  // sequencer: walks edges, divider steps and result transfers
  ppc_ctrl u_ctrl (
    .clk_i, .rst_ni, .in_valid_i, .in_stall_o,
    .status_i(status), .cmd_o(cmd)
  );

  ppc_datapath #(.MAX_VERTICES(MAX_VERTICES)) u_dp (
    .clk_i, .rst_ni, .cmd_i(cmd), .status_o(status),
    .plane_a_i(plane_a), .plane_b_i(plane_b), .plane_c_i(plane_c), .plane_d_i(plane_d),
    .in_x_i, .in_y_i, .in_z_i, .last_vertex_i,
    .out_stall_i, .out_valid_o, .out_x_o, .out_y_o, .out_z_o,
    .vertex_valid_o, .run_last_o, .polygon_done_o, .out_count_o
  );

  // count never passes its saturation bound
  a_count_cap: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (32'(out_count_o) <= CapInt))
    else $error("out_count above cap");

  // an empty result only closes a polygon
  a_empty_closes: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && !vertex_valid_o) |-> (run_last_o && polygon_done_o))
    else $error("empty result not closing polygon");

  // an empty result carries zero coordinates
  a_empty_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && !vertex_valid_o) |->
      (out_x_o == 32'd0 && out_y_o == 32'd0 && out_z_o == 32'd0))
    else $error("empty result with coordinates");

  // no new vertex is taken while results are still being produced
  a_busy_stall: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && !in_stall_o) |=> in_stall_o)
    else $error("input taken while busy");

endmodule

[verif/testbench.sv]
`timescale 1ns / 1ps

module testbench;

  localparam int unsigned MaxVertices = 64;
  localparam int unsigned CountCap = (MaxVertices + 1 < 127) ? MaxVertices + 1 : 127;
  localparam int unsigned CycleLimit = 400000;

  typedef struct packed {
    logic [31:0] x;
    logic [31:0] y;
    logic [31:0] z;
    logic        valid;
    logic        run_last;
    logic        done;
    logic [6:0]  count;
  } clip_vertex_t;

  // Clip scoreboard: tracks the plane and the polygon in flight, predicts the
  // clipped vertices of each accepted input vertex and checks them in order.
  class clip_scoreboard;
    longint signed plane[4];
    longint signed first_v[3];
    longint signed prev_v[3];
    bit            have_first;
    int unsigned   emitted;
    clip_vertex_t  pending[$];
    clip_vertex_t  batch[$];
    int unsigned   errors;
    int unsigned   checked;

    function void reset_state();
      plane[ppc_pkg::REG_A] = 0;
      plane[ppc_pkg::REG_B] = 0;
      plane[ppc_pkg::REG_C] = -65536;
      plane[ppc_pkg::REG_D] = 65536;
      have_first = 0;
      emitted = 0;
      foreach (first_v[i]) begin
        first_v[i] = 0;
        prev_v[i] = 0;
      end
    endfunction

    function void set_plane(ppc_pkg::reg_e idx, logic [31:0] value);
      plane[idx] = longint'(signed'(value));
    endfunction

    // >>> on a signed longint floors, which matches the rounding of the block
    function longint signed plane_eval(longint signed p[3]);
      return ((plane[ppc_pkg::REG_A] * p[0]) >>> 16) +
             ((plane[ppc_pkg::REG_B] * p[1]) >>> 16) +
             ((plane[ppc_pkg::REG_C] * p[2]) >>> 16) + plane[ppc_pkg::REG_D];
    endfunction

    function longint signed interp(longint signed p1, longint signed p2,
                                   longint unsigned t);
      longint signed   span;
      longint unsigned mag;
      longint unsigned off;
      span = p2 - p1;
      mag = span < 0 ? longint'(-span) : span;
      off = (mag * t + (64'd1 << (ppc_pkg::FracT - 1))) >> ppc_pkg::FracT;
      return span < 0 ? p1 - longint'(off) : p1 + longint'(off);
    endfunction

    function void emit(longint signed p[3], bit valid);
      clip_vertex_t r;
      if (batch.size() >= 4) return;
      if (valid && emitted < CountCap) emitted++;
      r.x = valid ? p[0][31:0] : '0;
      r.y = valid ? p[1][31:0] : '0;
      r.z = valid ? p[2][31:0] : '0;
      r.valid = valid;
      r.run_last = 0;
      r.done = 0;
      r.count = emitted[6:0];
      batch.push_back(r);
    endfunction

    function void clip_edge(longint signed a[3], longint signed b[3]);
      longint signed   va, vb, den, num;
      longint unsigned un, ud, rem, t;
      longint signed   ip[3];
      bit              ina, inb;
      va = plane_eval(a);
      vb = plane_eval(b);
      ina = va < 0;
      inb = vb < 0;
      if (!ina && !inb) return;
      if (ina && inb) begin
        emit(b, 1);
        return;
      end
      den = vb - va;
      if (den == 0) return;
      num = -va;
      un = num < 0 ? -num : num;
      ud = den < 0 ? -den : den;
      rem = un;
      t = 0;
      if (rem >= ud) begin
        t = 1;
        rem -= ud;
      end
      for (int i = 0; i < ppc_pkg::FracT; i++) begin
        rem = rem << 1;
        t = t << 1;
        if (rem >= ud) begin
          rem -= ud;
          t |= 1;
        end
      end
      foreach (ip[i]) ip[i] = interp(a[i], b[i], t);
      emit(ip, 1);
      if (inb) emit(b, 1);
    endfunction

    function void note_vertex(logic [31:0] x, logic [31:0] y, logic [31:0] z,
                              logic last);
      longint signed cur[3];
      longint signed zero3[3];
      cur[0] = longint'(signed'(x));
      cur[1] = longint'(signed'(y));
      cur[2] = longint'(signed'(z));
      foreach (zero3[i]) zero3[i] = 0;
      batch.delete();
      if (!have_first) begin
        first_v = cur;
        have_first = 1;
      end else begin
        clip_edge(prev_v, cur);
      end
      prev_v = cur;
      if (last) begin
        clip_edge(cur, first_v);
        if (batch.size() == 0) emit(zero3, 0);
        foreach (batch[k]) batch[k].done = 1;
        have_first = 0;
        emitted = 0;
      end
      if (batch.size() > 0) batch[batch.size() - 1].run_last = 1;
      foreach (batch[k]) pending.push_back(batch[k]);
    endfunction

    function void check_vertex(clip_vertex_t got);
      clip_vertex_t exp_v;
      checked++;
      if (pending.size() == 0) begin
        errors++;
        $display("%0t: unexpected vertex x=%h y=%h z=%h", $time, got.x, got.y, got.z);
        return;
      end
      exp_v = pending.pop_front();
      if (got != exp_v) begin
        errors++;
        $display("%0t: mismatch exp x=%h y=%h z=%h v=%b rl=%b pd=%b n=%0d", $time,
                 exp_v.x, exp_v.y, exp_v.z, exp_v.valid, exp_v.run_last, exp_v.done,
                 exp_v.count);
        $display("%0t:          got x=%h y=%h z=%h v=%b rl=%b pd=%b n=%0d", $time,
                 got.x, got.y, got.z, got.valid, got.run_last, got.done, got.count);
      end
    endfunction
  endclass

  logic        clk_i = 0;
  logic        rst_ni = 0;
  logic        psel = 0;
  logic        penable = 0;
  logic        pwrite = 0;
  logic [3:0]  paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic        pready;
  logic        in_valid_i = 0;
  logic        in_stall_o;
  logic [31:0] in_x_i = '0;
  logic [31:0] in_y_i = '0;
  logic [31:0] in_z_i = '0;
  logic        last_vertex_i = 0;
  logic        out_valid_o;
  logic        out_stall_i = 1;
  logic [31:0] out_x_o;
  logic [31:0] out_y_o;
  logic [31:0] out_z_o;
  logic        vertex_valid_o;
  logic        run_last_o;
  logic        polygon_done_o;
  logic [6:0]  out_count_o;

  clip_scoreboard clip_sb = new();
  int unsigned    cycle_count = 0;
  int unsigned    polygons_sent = 0;
  bit             drain_busy = 1;

  always #1 clk_i = ~clk_i;

  polygon_plane_clipper_unit #(.MAX_VERTICES(MaxVertices)) i_dut (
    .clk_i, .rst_ni, .psel, .penable, .pwrite, .paddr, .pwdata, .prdata, .pready,
    .in_valid_i, .in_stall_o, .in_x_i, .in_y_i, .in_z_i, .last_vertex_i,
    .out_valid_o, .out_stall_i, .out_x_o, .out_y_o, .out_z_o, .vertex_valid_o,
    .run_last_o, .polygon_done_o, .out_count_o
  );

  // Watchdog: end the run if the block hangs.
  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CycleLimit) begin
      $display("testbench: done, errors");
      $finish;
    end
  end

  // Check every output transfer at the rising edge.
  always @(posedge clk_i) begin
    clip_vertex_t got;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      got.x = out_x_o;
      got.y = out_y_o;
      got.z = out_z_o;
      got.valid = vertex_valid_o;
      got.run_last = run_last_o;
      got.done = polygon_done_o;
      got.count = out_count_o;
      clip_sb.check_vertex(got);
    end
  end

  // Receiver: draw a stall length per result, with stretches of no stalling.
  initial begin
    int unsigned hold;
    @(posedge rst_ni);
    while (drain_busy) begin
      @(negedge clk_i);
      hold = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 16);
      if ((cycle_count / 3000) % 2 == 1) hold = 0;
      if (hold > 0) begin
        out_stall_i <= 1;
        repeat (hold) @(negedge clk_i);
      end
      out_stall_i <= 0;
      // wait for one transfer before drawing again
      do @(posedge clk_i); while (!(out_valid_o && !out_stall_i) && drain_busy);
    end
  end

  // Write one plane register over APB: setup, then access.
  task automatic write_plane(ppc_pkg::reg_e idx, logic [31:0] value);
    @(negedge clk_i);
    psel <= 1;
    penable <= 0;
    pwrite <= 1;
    paddr <= 4'(idx) << 2;
    pwdata <= value;
    @(negedge clk_i);
    penable <= 1;
    do @(posedge clk_i); while (!pready);
    clip_sb.set_plane(idx, value);
    @(negedge clk_i);
    psel <= 0;
    penable <= 0;
    pwrite <= 0;
  endtask

  task automatic set_plane_all(logic [31:0] a, logic [31:0] b, logic [31:0] c,
                               logic [31:0] d);
    write_plane(ppc_pkg::REG_A, a);
    write_plane(ppc_pkg::REG_B, b);
    write_plane(ppc_pkg::REG_C, c);
    write_plane(ppc_pkg::REG_D, d);
  endtask

  // Send one vertex; hold the payload until the block takes the transfer.
  task automatic send_vertex(logic [31:0] x, logic [31:0] y, logic [31:0] z,
                             logic last, bit gaps);
    int unsigned gap;
    gap = gaps ? $urandom_range(0, 16) : 0;
    if (gap > 0) begin
      in_valid_i <= 0;
      repeat (gap) @(negedge clk_i);
    end
    in_valid_i <= 1;
    in_x_i <= x;
    in_y_i <= y;
    in_z_i <= z;
    last_vertex_i <= last;
    do @(posedge clk_i); while (in_stall_o);
    clip_sb.note_vertex(x, y, z, last);
    if (last) polygons_sent++;
    @(negedge clk_i);
  endtask

  task automatic go_idle();
    in_valid_i <= 0;
    while (clip_sb.pending.size() != 0) @(negedge clk_i);
    // a vertex with no results may still be running its edges
    repeat (300) @(negedge clk_i);
  endtask

  function automatic logic [31:0] any_coord();
    case ($urandom_range(0, 3))
      0: return $urandom();
      1: return 32'($urandom_range(0, 8 * 65536)) - 32'(4 * 65536);
      2: return $urandom_range(0, 1) ? 32'h7FFF_FFFF : 32'h8000_0000;
      default: return 32'($urandom_range(0, 1024)) - 32'd512;
    endcase
  endfunction

  function automatic logic [31:0] any_coef();
    case ($urandom_range(0, 3))
      0: return $urandom();
      1: return 32'($urandom_range(0, 4 * 65536)) - 32'(2 * 65536);
      2: return $urandom_range(0, 1) ? 32'h7FFF_FFFF : 32'h8000_0000;
      default: return 32'($urandom_range(0, 4)) * 32'h0000_8000 - 32'h0001_0000;
    endcase
  endfunction

  initial begin
    int unsigned sent;
    int unsigned n;
    bit          gaps;
    clip_sb.reset_state();
    repeat (9) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1;
    @(negedge clk_i);

    // Directed: default plane keeps z > 1. Triangle crossing the plane.
    send_vertex(32'h0, 32'h0, 32'h0, 0, 0);
    send_vertex(32'h0002_0000, 32'h0, 32'h0002_0000, 0, 0);
    send_vertex(32'h0, 32'h0002_0000, 32'h0, 1, 0);
    // Fully outside square (invalid result), then fully inside triangle.
    send_vertex(32'h0, 32'h0, 32'hFFFF_0000, 0, 0);
    send_vertex(32'h0001_0000, 32'h0, 32'h0, 0, 0);
    send_vertex(32'h0001_0000, 32'h0001_0000, 32'h0, 0, 0);
    send_vertex(32'h0, 32'h0001_0000, 32'h8000_0000, 1, 0);
    send_vertex(32'h0, 32'h0, 32'h0005_0000, 0, 0);
    send_vertex(32'h1, 32'h0, 32'h7FFF_FFFF, 0, 0);
    send_vertex(32'h0, 32'h1, 32'h0003_0000, 1, 0);
    // Single-vertex polygons, inside and outside; out-to-in closing edge.
    send_vertex(32'h7FFF_FFFF, 32'h8000_0000, 32'h0, 1, 0);
    send_vertex(32'h8000_0000, 32'h7FFF_FFFF, 32'h0002_0000, 1, 0);
    send_vertex(32'h0, 32'h0, 32'h0004_0000, 0, 0);
    send_vertex(32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'h0, 1, 0);
    go_idle();
    // Extreme plane, then a plane through the origin on x.
    set_plane_all(32'h8000_0000, 32'h7FFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF);
    send_vertex(32'h7FFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF, 0, 0);
    send_vertex(32'h8000_0000, 32'h7FFF_FFFF, 32'h8000_0000, 0, 0);
    send_vertex(32'h0001_0000, 32'hFFFF_0000, 32'h0, 1, 0);
    go_idle();
    set_plane_all(32'h0001_0000, 32'h0, 32'h0, 32'h0);
    send_vertex(32'hFFFF_0000, 32'h0, 32'h0, 0, 0);
    send_vertex(32'h0001_0000, 32'h0, 32'h0, 0, 0);
    send_vertex(32'h0, 32'h0001_0000, 32'h0, 1, 0);
    sent = 20;

    // Plane that keeps every point inside: one long polygon pushes the count
    // to saturation.
    go_idle();
    set_plane_all(32'h0, 32'h0, 32'h0, 32'hFFFF_0000);
    n = $urandom_range(66, 70);
    for (int i = 0; i < n; i++) begin
      send_vertex($urandom(), $urandom(), $urandom(), i == n - 1, 0);
      sent++;
    end

    // Random short polygons against random planes.
    while (sent < 130) begin
      if ($urandom_range(0, 2) == 0) begin
        go_idle();
        set_plane_all(any_coef(), any_coef(), any_coef(), any_coef());
      end
      n = $urandom_range(1, 7);
      gaps = $urandom_range(0, 3) != 0;
      for (int i = 0; i < n; i++) begin
        send_vertex(any_coord(), any_coord(), any_coord(), i == n - 1, gaps);
        sent++;
      end
    end
    in_valid_i <= 0;
    while (clip_sb.pending.size() != 0) @(negedge clk_i);
    repeat (300) @(negedge clk_i);
    drain_busy = 0;
    $display("testbench: %0d vertices in %0d polygons, %0d clipped results checked",
             sent, polygons_sent, clip_sb.checked);
    if (clip_sb.errors == 0) begin
      $display("testbench: done, clean");
    end else begin
      $display("testbench: done, errors");
    end
    $finish;
  end

endmodule
